@@ rtl/blrs_pkg.sv @@
// ----------------------------------------------------------------------------
// blrs_pkg: shared types and constants for the binary lens ray accumulator
// Holds the transfer payload structs, the sequencer states, the register map
// and the fixed-point constants used by the core and its divider.
// ----------------------------------------------------------------------------
package blrs_pkg;

   // default fixed-point geometry
   localparam int COORD_FRAC_BITS_DEF = 24;
   localparam int ACC_WIDTH_DEF       = 48;

   // unity in Q.16 and the clip values
   localparam logic [16:0] ONE_Q16   = 17'd65536;
   localparam logic [46:0] TERM_LIM  = 47'h7FFF_FFFF_FFFF;
   localparam logic [47:0] OUT48_MAX = 48'hFFFF_FFFF_FFFF;

   // register map, one register per 32-bit word
   localparam int CSR_ADDR_WIDTH = 5;

   typedef enum logic [2:0] {
      REG_SOURCE_X      = 3'd0,
      REG_SOURCE_Y      = 3'd1,
      REG_RADIUS_SQ     = 3'd2,
      REG_INV_RADIUS_SQ = 3'd3,
      REG_LIMB_COEFF    = 3'd4,
      REG_PRIMARY_MASS  = 3'd5,
      REG_SEPARATION    = 3'd6,
      REG_OUTPUT_SCALE  = 3'd7
   } csr_index_type;

   // input transfer
   typedef struct packed {
      logic signed [31:0] ray_x;
      logic signed [31:0] ray_y;
      logic               last_ray;
   } ray_req_type;

   // result transfer
   typedef struct packed {
      logic [31:0] magnification;
      logic [31:0] rays_inside;
      logic [47:0] brightness_total;
      logic        saturated;
   } ray_rsp_type;

   // divider handshake
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // sequencer states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQ_D,
      ST_SUM_R2,
      ST_NUM,
      ST_DIV,
      ST_DWAIT,
      ST_EX,
      ST_SQ_EX,
      ST_SQ_EY,
      ST_SUM_D2,
      ST_RATIO_MUL,
      ST_ROOT_INIT,
      ST_ROOT,
      ST_BR_MUL,
      ST_ACC,
      ST_FIN,
      ST_HI_MUL,
      ST_LO_MUL,
      ST_EMIT
   } seq_state_type;

   // magnitude of a 33-bit signed value
   function automatic logic [32:0] abs33(input logic signed [32:0] v);
      logic [32:0] r;
      r = v[32] ? 33'(-v) : 33'(v);
      return r;
   endfunction

endpackage

@@ rtl/blrs_div.sv @@
// ----------------------------------------------------------------------------
// blrs_div: restoring divider, one quotient bit per cycle
// Unsigned num / den, quotient valid when done is raised; den must be non-zero.
// ----------------------------------------------------------------------------
module blrs_div
   import blrs_pkg::*;
#(
   parameter int NUM_WIDTH = 57,
   parameter int DEN_WIDTH = 41
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_WIDTH-1:0] num,
   input  logic [DEN_WIDTH-1:0] den,
   output logic [NUM_WIDTH-1:0] quot,
   output div_status_type       status
);

   localparam int CW = $clog2(NUM_WIDTH);

   logic [DEN_WIDTH-1:0] rem_ff;
   logic [NUM_WIDTH-1:0] quo_ff;
   logic [DEN_WIDTH-1:0] den_ff;
   logic [CW-1:0]        cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;

   logic [DEN_WIDTH:0]   rem_sh;
   logic                 ge;
   logic [DEN_WIDTH-1:0] rem_in;

   // shift in the next numerator bit and trial-subtract
   always_comb begin
      rem_sh = {rem_ff, quo_ff[NUM_WIDTH-1]};
      ge     = rem_sh >= {1'b0, den_ff};
      rem_in = ge ? DEN_WIDTH'(rem_sh - {1'b0, den_ff}) : rem_sh[DEN_WIDTH-1:0];
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(NUM_WIDTH - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= num;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[NUM_WIDTH-2:0], ge};
      end
   end

   assign quot        = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

@@ rtl/binary_lens_ray_shoot_accumulator_core.sv @@
// ----------------------------------------------------------------------------
// binary_lens_ray_shoot_accumulator_core: inverse ray shooting through two
// point lenses with limb-darkened source accumulation
// Maps each ray to the source plane, tests it against the source disc and
// sums brightness; emits magnification, count and sum on the last ray.
// ----------------------------------------------------------------------------
// One ray is taken at a time and occupies the block until it is done, less long
// when the ray misses the source; the four lens-term divisions through the
// shared bit-serial divider dominate, then a 17-step square root, all other
// arithmetic going through one shared 33x33 multiplier. req_stall is high
// while a ray is in work. The last ray of a batch adds the result scaling
// (ST_HI_MUL, ST_LO_MUL, ST_EMIT) and its result sits in an output register,
// so the next ray can enter while that result waits to be taken.
module binary_lens_ray_shoot_accumulator_core
   import blrs_pkg::*;
#(
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
   parameter int ACC_WIDTH       = ACC_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // ray input
   input  logic                      req_valid,
   output logic                      req_stall,
   input  ray_req_type               req_payload,
   // result output
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output ray_rsp_type               rsp_payload,
   // register port
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   localparam int K  = COORD_FRAC_BITS - 16;
   localparam int RW = 65 - COORD_FRAC_BITS;
   localparam int NW = 49 + K;
   localparam int XW = 50;
   localparam int EW = 51;
   localparam int TW = (ACC_WIDTH > 48) ? ACC_WIDTH : 48;

   // configuration registers
   logic signed [31:0] source_x_ff;
   logic signed [31:0] source_y_ff;
   logic [30:0]        radius_sq_ff;
   logic [31:0]        inv_radius_sq_ff;
   logic [16:0]        limb_coeff_ff;
   logic [16:0]        primary_mass_ff;
   logic [30:0]        separation_ff;
   logic [31:0]        output_scale_ff;

   // sequencer and datapath
   seq_state_type      state_ff, state_in;
   logic signed [31:0] xi_ff, yi_ff;
   logic signed [32:0] dx2_ff;
   logic               last_ff;
   logic [RW-1:0]      r1_ff, r2_ff, d2_ff;
   logic [1:0]         idx_ff;
   logic signed [XW-1:0] x_ff, y_ff;
   logic [EW-1:0]      exm_ff, eym_ff;
   logic               far_ff;
   logic [33:0]        v_ff, rt_ff, bit_ff;
   logic [65:0]        prod_ff;
   logic [63:0]        hiprod_ff;
   logic [31:0]        count_ff;
   logic [ACC_WIDTH-1:0] acc_ff;
   logic               ovf_ff;
   logic               rsp_valid_ff;
   ray_rsp_type        rsp_ff;

   // shared unit controls
   logic [32:0]        op_a, op_b;
   logic               div_start;
   logic [NW-1:0]      div_num, div_quot;
   logic [RW-1:0]      div_den;
   div_status_type     div_st;

   // derived values
   logic               csr_wr;
   logic               out_free;
   logic [16:0]        mass2;
   logic [RW-1:0]      sq_sh;
   logic [16:0]        mass_sel;
   logic signed [32:0] d_sel;
   logic [RW-1:0]      r_sel;
   logic [46:0]        term_mag;
   logic               term_ovf;
   logic signed [EW-1:0] ex, ey;
   logic [16:0]        u_val;
   logic [33:0]        trial;
   logic               root_ge;
   logic [16:0]        c_val;
   logic [18:0]        c3;
   logic signed [17:0] a_val;
   logic [16:0]        a_mag;
   logic signed [19:0] br_term, br_s;
   logic [18:0]        br;
   logic [ACC_WIDTH:0] acc_sum;
   logic [63:0]        acc64;
   logic [32:0]        mag_sum;
   logic               mag_sat;
   logic [TW-1:0]      acc_t;

   assign pready   = 1'b1;
   assign csr_wr   = psel & penable & pwrite;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         source_x_ff      <= '0;
         source_y_ff      <= '0;
         radius_sq_ff     <= 31'd16777216;
         inv_radius_sq_ff <= 32'd65536;
         limb_coeff_ff    <= '0;
         primary_mass_ff  <= ONE_Q16;
         separation_ff    <= 31'd16777216;
         output_scale_ff  <= '0;
      end else if (csr_wr) begin
         case (csr_index_type'(paddr[4:2]))
            REG_SOURCE_X:      source_x_ff      <= $signed(pwdata);
            REG_SOURCE_Y:      source_y_ff      <= $signed(pwdata);
            REG_RADIUS_SQ:     radius_sq_ff     <= pwdata[30:0];
            REG_INV_RADIUS_SQ: inv_radius_sq_ff <= pwdata;
            REG_LIMB_COEFF:    limb_coeff_ff    <= pwdata[16:0];
            REG_PRIMARY_MASS:  primary_mass_ff  <= pwdata[16:0];
            REG_SEPARATION:    separation_ff    <= pwdata[30:0];
            REG_OUTPUT_SCALE:  output_scale_ff  <= pwdata;
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      case (csr_index_type'(paddr[4:2]))
         REG_SOURCE_X:      prdata = source_x_ff;
         REG_SOURCE_Y:      prdata = source_y_ff;
         REG_RADIUS_SQ:     prdata = {1'b0, radius_sq_ff};
         REG_INV_RADIUS_SQ: prdata = inv_radius_sq_ff;
         REG_LIMB_COEFF:    prdata = {15'd0, limb_coeff_ff};
         REG_PRIMARY_MASS:  prdata = {15'd0, primary_mass_ff};
         REG_SEPARATION:    prdata = {1'b0, separation_ff};
         REG_OUTPUT_SCALE:  prdata = output_scale_ff;
         default:           prdata = '0;
      endcase
   end

   // shared divider
   blrs_div #(
      .NUM_WIDTH(NW),
      .DEN_WIDTH(RW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .quot  (div_quot),
      .status(div_st)
   );

   // combinational datapath pieces
   always_comb begin
      mass2    = (primary_mass_ff >= ONE_Q16) ? 17'd0 : 17'(ONE_Q16 - primary_mass_ff);
      sq_sh    = RW'(prod_ff >> COORD_FRAC_BITS);
      mass_sel = idx_ff[1] ? mass2 : primary_mass_ff;
      r_sel    = idx_ff[1] ? r2_ff : r1_ff;
      case (idx_ff)
         2'd0:    d_sel = $signed({xi_ff[31], xi_ff});
         2'd2:    d_sel = dx2_ff;
         default: d_sel = $signed({yi_ff[31], yi_ff});
      endcase
      div_num = NW'(prod_ff[48:0]) << K;
      div_den = r_sel;
      // clip the lens term; a zero distance saturates
      if (state_ff == ST_DIV) begin
         term_ovf = 1'b1;
         term_mag = (d_sel == 33'sd0) ? 47'd0 : TERM_LIM;
      end else begin
         term_ovf = div_quot > NW'(TERM_LIM);
         term_mag = term_ovf ? TERM_LIM : div_quot[46:0];
      end
      ex = $signed({x_ff[XW-1], x_ff}) - EW'(source_x_ff);
      ey = $signed({y_ff[XW-1], y_ff}) - EW'(source_y_ff);
      u_val = ((prod_ff >> COORD_FRAC_BITS) > 66'd65536) ? 17'd0
            : 17'(66'd65536 - (prod_ff >> COORD_FRAC_BITS));
      trial   = rt_ff + bit_ff;
      root_ge = v_ff >= trial;
      c_val   = rt_ff[16:0];
      c3      = {2'b0, c_val} + {1'b0, c_val, 1'b0};
      a_val   = 18'sd65536 - $signed({1'b0, c3[17:1]});
      a_mag   = a_val[17] ? 17'(-a_val) : a_val[16:0];
      br_term = a_val[17] ? -$signed({2'b0, prod_ff[33:16]})
                          : $signed({2'b0, prod_ff[33:16]});
      br_s    = 20'sd65536 - br_term;
      br      = (br_s <= 20'sd0) ? 19'd0 : br_s[18:0];
      acc_sum = {1'b0, acc_ff} + (ACC_WIDTH + 1)'(br);
      acc64   = 64'(acc_ff);
      mag_sum = {1'b0, hiprod_ff[31:0]} + 33'(prod_ff[63:32]);
      mag_sat = (|hiprod_ff[63:32]) | mag_sum[32];
      acc_t   = TW'(acc_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_SQ_X;
         ST_SQ_X:      state_in = ST_SQ_Y;
         ST_SQ_Y:      state_in = ST_SQ_D;
         ST_SQ_D:      state_in = ST_SUM_R2;
         ST_SUM_R2:    state_in = ST_NUM;
         ST_NUM:       state_in = ST_DIV;
         ST_DIV: begin
            if (r_sel != '0)          state_in = ST_DWAIT;
            else if (idx_ff == 2'd3)  state_in = ST_EX;
            else                      state_in = ST_NUM;
         end
         ST_DWAIT: begin
            if (div_st.done) state_in = (idx_ff == 2'd3) ? ST_EX : ST_NUM;
         end
         ST_EX:        state_in = ST_SQ_EX;
         ST_SQ_EX:     state_in = far_ff ? ST_FIN : ST_SQ_EY;
         ST_SQ_EY:     state_in = ST_SUM_D2;
         ST_SUM_D2:    state_in = ST_RATIO_MUL;
         ST_RATIO_MUL: state_in = (d2_ff > RW'(radius_sq_ff)) ? ST_FIN : ST_ROOT_INIT;
         ST_ROOT_INIT: state_in = ST_ROOT;
         ST_ROOT:      if (bit_ff[0]) state_in = ST_BR_MUL;
         ST_BR_MUL:    state_in = ST_ACC;
         ST_ACC:       state_in = ST_FIN;
         ST_FIN:       state_in = last_ff ? ST_HI_MUL : ST_IDLE;
         ST_HI_MUL:    state_in = ST_LO_MUL;
         ST_LO_MUL:    state_in = ST_EMIT;
         ST_EMIT:      if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // per-state outputs: multiplier operands, divider start, input stall
   always_comb begin
      op_a      = '0;
      op_b      = '0;
      div_start = 1'b0;
      req_stall = state_ff != ST_IDLE;
      case (state_ff)
         ST_SQ_X: begin
            op_a = abs33($signed({xi_ff[31], xi_ff}));
            op_b = op_a;
         end
         ST_SQ_Y: begin
            op_a = abs33($signed({yi_ff[31], yi_ff}));
            op_b = op_a;
         end
         ST_SQ_D: begin
            op_a = abs33(dx2_ff);
            op_b = op_a;
         end
         ST_NUM: begin
            op_a = 33'(mass_sel);
            op_b = abs33(d_sel);
         end
         ST_DIV:       div_start = r_sel != '0;
         ST_SQ_EX: begin
            op_a = 33'(exm_ff[31:0]);
            op_b = op_a;
         end
         ST_SQ_EY: begin
            op_a = 33'(eym_ff[31:0]);
            op_b = op_a;
         end
         ST_RATIO_MUL: begin
            op_a = 33'(d2_ff[30:0]);
            op_b = 33'(inv_radius_sq_ff);
         end
         ST_BR_MUL: begin
            op_a = 33'(limb_coeff_ff);
            op_b = 33'(a_mag);
         end
         ST_HI_MUL: begin
            op_a = 33'(acc64[63:32]);
            op_b = 33'(output_scale_ff);
         end
         ST_LO_MUL, ST_EMIT: begin
            op_a = 33'(acc64[31:0]);
            op_b = 33'(output_scale_ff);
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         acc_ff       <= '0;
         ovf_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;
         // raise the result flag on a new transfer, drop it once taken
         if (state_ff == ST_EMIT && out_free) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)                 rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_DIV:   if (r_sel == '0) ovf_ff <= 1'b1;
            ST_DWAIT: if (div_st.done && term_ovf) ovf_ff <= 1'b1;
            ST_ACC: begin
               // count and sum the ray, saturating
               if ((count_ff == 32'hFFFF_FFFF) || acc_sum[ACC_WIDTH]) ovf_ff <= 1'b1;
               if (count_ff != 32'hFFFF_FFFF) count_ff <= count_ff + 1'b1;
               if (acc_sum[ACC_WIDTH]) begin
                  acc_ff <= '1;
               end else begin
                  acc_ff <= acc_sum[ACC_WIDTH-1:0];
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  count_ff     <= '0;
                  acc_ff       <= '0;
                  ovf_ff       <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
      case (state_ff)
         ST_IDLE: begin
            xi_ff   <= req_payload.ray_x;
            yi_ff   <= req_payload.ray_y;
            last_ff <= req_payload.last_ray;
            dx2_ff  <= $signed({req_payload.ray_x[31], req_payload.ray_x})
                     + $signed({2'b0, separation_ff});
            x_ff    <= XW'(req_payload.ray_x);
            y_ff    <= XW'(req_payload.ray_y);
         end
         ST_SQ_Y:   r1_ff <= sq_sh;
         ST_SQ_D: begin
            r1_ff <= r1_ff + sq_sh;
            r2_ff <= sq_sh;
         end
         ST_SUM_R2: begin
            r2_ff  <= r2_ff + sq_sh;
            idx_ff <= 2'd0;
         end
         ST_DIV, ST_DWAIT: begin
            // apply the lens term to x or y and step to the next one
            if (state_ff == ST_DIV ? (r_sel == '0) : div_st.done) begin
               if (idx_ff[0]) begin
                  y_ff <= d_sel[32] ? y_ff + XW'(term_mag) : y_ff - XW'(term_mag);
               end else begin
                  x_ff <= d_sel[32] ? x_ff + XW'(term_mag) : x_ff - XW'(term_mag);
               end
               idx_ff <= idx_ff + 1'b1;
            end
         end
         ST_EX: begin
            exm_ff <= ex[EW-1] ? EW'(-ex) : EW'(ex);
            eym_ff <= ey[EW-1] ? EW'(-ey) : EW'(ey);
            far_ff <= (ex[EW-1] ? (|(EW'(-ex) >> 32)) : (|(EW'(ex) >> 32)))
                    | (ey[EW-1] ? (|(EW'(-ey) >> 32)) : (|(EW'(ey) >> 32)));
         end
         ST_SQ_EY:  d2_ff <= sq_sh;
         ST_SUM_D2: d2_ff <= d2_ff + sq_sh;
         ST_ROOT_INIT: begin
            v_ff   <= {1'b0, u_val, 16'd0};
            rt_ff  <= '0;
            bit_ff <= 34'h1_0000_0000;
         end
         ST_ROOT: begin
            // one digit of the bitwise square root
            if (root_ge) begin
               v_ff  <= v_ff - trial;
               rt_ff <= (rt_ff >> 1) + bit_ff;
            end else begin
               rt_ff <= rt_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         ST_LO_MUL: hiprod_ff <= prod_ff[63:0];
         ST_EMIT: begin
            if (out_free) begin
               rsp_ff.magnification    <= mag_sat ? 32'hFFFF_FFFF : mag_sum[31:0];
               rsp_ff.rays_inside      <= count_ff;
               rsp_ff.brightness_total <= (acc_t > TW'(OUT48_MAX)) ? OUT48_MAX
                                                                   : acc_t[47:0];
               rsp_ff.saturated        <= ovf_ff | mag_sat;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the binary lens ray accumulator core
// Drives directed and random rays with random gaps and stalls, predicts each
// batch result with a bit-exact fixed-point model and checks every transfer.
// ----------------------------------------------------------------------------
import blrs_pkg::*;

class lens_batch_scoreboard;
   // register copy
   logic signed [63:0] src_x, src_y;
   logic [63:0] rad_sq, inv_rsq, gamma, m1_frac, separation, out_scale;
   // running batch state
   logic [63:0] hit_count, bright_sum;
   bit          sat_flag;
   ray_rsp_type pending_results[$];
   int          errors;

   function void clear_regs();
      src_x = 0; src_y = 0; rad_sq = 64'd16777216; inv_rsq = 64'd65536;
      gamma = 0; m1_frac = 64'd65536; separation = 64'd16777216; out_scale = 0;
      hit_count = 0; bright_sum = 0; sat_flag = 0; errors = 0;
   endfunction

   function void set_reg(csr_index_type idx, logic [31:0] v);
      case (idx)
         REG_SOURCE_X:      src_x = $signed(v);
         REG_SOURCE_Y:      src_y = $signed(v);
         REG_RADIUS_SQ:     rad_sq = {33'd0, v[30:0]};
         REG_INV_RADIUS_SQ: inv_rsq = {32'd0, v};
         REG_LIMB_COEFF:    gamma = {47'd0, v[16:0]};
         REG_PRIMARY_MASS:  m1_frac = {47'd0, v[16:0]};
         REG_SEPARATION:    separation = {33'd0, v[30:0]};
         default:           out_scale = {32'd0, v};
      endcase
   endfunction

   function logic [63:0] magn(logic signed [63:0] v);
      return v < 0 ? -v : v;
   endfunction

   function logic [63:0] sq_trunc(logic signed [63:0] v);
      logic [63:0] m;
      m = magn(v);
      return (m * m) >> 24;
   endfunction

   // deflection by one lens, clipped to 47 bits
   function logic signed [63:0] deflect(logic [63:0] mass, logic signed [63:0] d,
                                        logic [63:0] r2);
      logic [63:0] m, num, q, rem, res;
      m = magn(d);
      if (r2 == 0) begin
         sat_flag = 1;
         if (d == 0) return 0;
         res = TERM_LIM;
      end else begin
         num = mass * m;
         q = num / r2;
         rem = num % r2;
         if (q > (64'(TERM_LIM) >> 8)) begin
            sat_flag = 1;
            res = TERM_LIM;
         end else begin
            res = (q << 8) + ((rem << 8) / r2);
            if (res > TERM_LIM) begin
               sat_flag = 1;
               res = TERM_LIM;
            end
         end
      end
      return d < 0 ? -$signed(res) : $signed(res);
   endfunction

   function logic [63:0] int_root(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else r = r >> 1;
         b = b >> 2;
      end
      return r;
   endfunction

   function void shoot_ray(logic signed [63:0] xi, logic signed [63:0] yi);
      logic [63:0] m2, r1, r2, d2, ratio, u, c, c15, p, br;
      logic signed [63:0] dx2, x, y, ex, ey, a, term;
      m2 = m1_frac >= 65536 ? 64'd0 : 64'd65536 - m1_frac;
      dx2 = xi + $signed(separation);
      r1 = sq_trunc(xi) + sq_trunc(yi);
      r2 = sq_trunc(dx2) + sq_trunc(yi);
      x = xi - deflect(m1_frac, xi, r1) - deflect(m2, dx2, r2);
      y = yi - deflect(m1_frac, yi, r1) - deflect(m2, yi, r2);
      ex = x - src_x;
      ey = y - src_y;
      if (magn(ex) >= 64'h1_0000_0000 || magn(ey) >= 64'h1_0000_0000) return;
      d2 = sq_trunc(ex) + sq_trunc(ey);
      if (d2 > rad_sq) return;
      ratio = (d2 * inv_rsq) >> 24;
      if (ratio > 65536) ratio = 65536;
      u = 65536 - ratio;
      c = int_root(u << 16);
      c15 = (3 * c) >> 1;
      a = 64'sd65536 - $signed(c15);
      p = (gamma * magn(a)) >> 16;
      term = a < 0 ? -$signed(p) : $signed(p);
      br = term >= 65536 ? 64'd0 : 64'(64'sd65536 - term);
      if (hit_count == 64'hFFFF_FFFF) sat_flag = 1;
      else hit_count++;
      if (bright_sum > 64'(OUT48_MAX) - br) begin
         sat_flag = 1;
         bright_sum = OUT48_MAX;
      end else bright_sum += br;
   endfunction

   // note one accepted ray; a last ray queues the batch result
   function void note_ray(ray_req_type r);
      logic [63:0] hi, lo, mg;
      ray_rsp_type e;
      bit f;
      shoot_ray(64'(r.ray_x), 64'(r.ray_y));
      if (!r.last_ray) return;
      f = sat_flag;
      hi = bright_sum >> 32;
      lo = bright_sum & 64'hFFFF_FFFF;
      if (hi * out_scale > 64'hFFFF_FFFF) begin
         mg = 64'hFFFF_FFFF;
         f = 1;
      end else begin
         mg = hi * out_scale + ((lo * out_scale) >> 32);
         if (mg > 64'hFFFF_FFFF) begin
            mg = 64'hFFFF_FFFF;
            f = 1;
         end
      end
      e.magnification = mg[31:0];
      e.rays_inside = hit_count[31:0];
      e.brightness_total = bright_sum[47:0];
      e.saturated = f;
      pending_results = {pending_results, e};
      hit_count = 0; bright_sum = 0; sat_flag = 0;
   endfunction

   function void check_result(ray_rsp_type got);
      ray_rsp_type e;
      if (pending_results.size() == 0) begin
         $error("unexpected result transfer %h", got);
         errors++;
         return;
      end
      e = pending_results.pop_front();
      if (got.magnification !== e.magnification) begin
         $error("magnification: expected %h, got %h", e.magnification, got.magnification);
         errors++;
      end
      if (got.rays_inside !== e.rays_inside) begin
         $error("rays_inside: expected %0d, got %0d", e.rays_inside, got.rays_inside);
         errors++;
      end
      if (got.brightness_total !== e.brightness_total) begin
         $error("brightness_total: expected %h, got %h", e.brightness_total,
                got.brightness_total);
         errors++;
      end
      if (got.saturated !== e.saturated) begin
         $error("saturated: expected %b, got %b", e.saturated, got.saturated);
         errors++;
      end
   endfunction
endclass

module tb_top;
   localparam int CYCLE_LIMIT = 2_000_000;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall;
   ray_req_type req_payload = '0;
   logic rsp_valid, rsp_stall = 0;
   ray_rsp_type rsp_payload;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [31:0] pwdata = '0, prdata;
   logic pready;
   int cycles = 0;
   int stall_left = 0;
   bit stim_done = 0;
   lens_batch_scoreboard sb;

   always #5 clock = ~clock;

   binary_lens_ray_shoot_accumulator_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   function int gap_len();
      int k;
      k = $urandom_range(0, 99);
      if (k < 40) return 0;
      if (k < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // check result transfers and toggle the stall in runs of random length
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_payload);
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
         end else begin
            rsp_stall  <= ~rsp_stall;
            stall_left <= rsp_stall ? $urandom_range(0, 4) : gap_len();
         end
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic write_reg(csr_index_type idx, logic [31:0] v);
      psel <= 1; penable <= 0; pwrite <= 1;
      paddr <= CSR_ADDR_WIDTH'({idx, 2'b00}); pwdata <= v;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      sb.set_reg(idx, v);
   endtask

   task automatic send_ray(logic [31:0] x, logic [31:0] y, bit last_one);
      ray_req_type r;
      int g;
      r.ray_x = x; r.ray_y = y; r.last_ray = last_one;
      req_valid <= 1; req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_ray(r);
      g = gap_len();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
   endtask

   // drain results and let the core finish any trailing ray
   task automatic settle();
      req_valid <= 0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic random_setting(bit extreme);
      write_reg(REG_SOURCE_X, extreme ? 32'h8000_0000
                : $urandom_range(0, 32'h0400_0000) - 32'h0200_0000);
      write_reg(REG_SOURCE_Y, extreme ? 32'h7FFF_FFFF
                : $urandom_range(0, 32'h0400_0000) - 32'h0200_0000);
      write_reg(REG_RADIUS_SQ, extreme ? 32'h7FFF_FFFF
                : $urandom_range(32'h0004_0000, 32'h0400_0000));
      write_reg(REG_INV_RADIUS_SQ, extreme ? 32'hFFFF_FFFF
                : $urandom_range(32'h400, 32'h0040_0000));
      write_reg(REG_LIMB_COEFF, extreme ? 32'h1_0000 : $urandom_range(0, 32'h1_FFFF));
      write_reg(REG_PRIMARY_MASS, extreme ? 32'h8000 : $urandom_range(32'h8000, 32'h1_FFFF));
      write_reg(REG_SEPARATION, extreme ? 32'h7FFF_FFFF
                : $urandom_range(0, 32'h0300_0000));
      write_reg(REG_OUTPUT_SCALE, extreme ? 32'hFFFF_FFFF : $urandom());
   endtask

   function logic [31:0] rand_coord();
      int k;
      k = $urandom_range(0, 9);
      if (k == 0) return $urandom();
      if (k == 1) return $urandom_range(0, 3) - 1;
      return $urandom_range(0, 32'h0600_0000) - 32'h0300_0000;
   endfunction

   initial begin
      int p, n;
      sb = new();
      sb.clear_regs();
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset registers, origin, lens positions and extremes
      send_ray(32'h0, 32'h0, 0);
      send_ray(32'hFF00_0000, 32'h0, 0);
      send_ray(32'h8000_0000, 32'h8000_0000, 0);
      send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
      send_ray(32'h0100_0000, 32'h0000_0001, 1);
      send_ray(32'h0180_0000, 32'h0, 1);
      settle();
      write_reg(REG_OUTPUT_SCALE, 32'hFFFF_FFFF);
      write_reg(REG_LIMB_COEFF, 32'h1_FFFF);
      write_reg(REG_PRIMARY_MASS, 32'h1_0001);
      write_reg(REG_INV_RADIUS_SQ, 32'hFFFF_FFFF);
      write_reg(REG_RADIUS_SQ, 32'h7FFF_FFFF);
      write_reg(REG_SEPARATION, 32'h0);
      for (int i = 0; i < 6; i++) send_ray(32'h0180_0000 + i, 32'h0010_0000 * i, i == 5);
      send_ray(32'h0000_0001, 32'hFFFF_FFFF, 1);
      settle();
      random_setting(1);
      send_ray(32'h8000_0000, 32'h7FFF_FFFF, 0);
      send_ray(32'h0, 32'h0, 1);
      settle();

      // random phases with fresh settings
      n = 0;
      for (p = 0; p < 12; p++) begin
         settle();
         random_setting(p == 6);
         while (n < 62 * (p + 1)) begin
            send_ray(rand_coord(), rand_coord(), $urandom_range(0, 5) == 0);
            n++;
         end
         send_ray(rand_coord(), rand_coord(), 1);
      end
      settle();
      stim_done = 1;
      if (sb.errors == 0 && sb.pending_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
